>>> hw/rtl/ogs_pkg.sv
// Shared types, codes and constants for the occupancy grid store.
package ogs_pkg;

    localparam int unsigned DEF_MAX_COLUMNS = 256;
    localparam int unsigned DEF_MAX_ROWS    = 256;

    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned BIT_SEL_W = 5;

    localparam int unsigned DIM_W      = 9;
    localparam int unsigned POS_W      = 10;
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned TALLY_W    = 17;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 9;

    typedef enum logic [KIND_W-1:0] {
        KIND_QUERY     = 3'd0,
        KIND_SET       = 3'd1,
        KIND_CLEAR     = 3'd2,
        KIND_FILL      = 3'd3,
        KIND_CLEAR_ALL = 3'd4
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_WIDTH  = 1'd0,
        CFG_MAP_HEIGHT = 1'd1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL_RD,
        ST_CELL_WR,
        ST_QUERY_RD,
        ST_RESULT
    } state_t;

    // Zero acts as one, values above the limit saturate to it.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned lim);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (32'(v) > lim) begin
            r = lim[DIM_W-1:0];
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/ogs_mem.sv
// Single-port-write, single-port-read word memory with registered read data.
module ogs_mem #(
    parameter int unsigned DEPTH  = 2048,
    parameter int unsigned ADDR_W = 11,
    parameter int unsigned DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/occupancy_grid_store.sv
// Occupancy grid store: one-bit-per-cell obstacle map with a running obstacle count.
//
// The map lives in one word-wide memory, cells packed 32 to a word in row-major
// order (cell = row * width + column), and every cell write is a read-modify-write of
// one word. A query or an out-of-map write reads its word once and then returns the
// result; a set, clear or fill of an in-map area first reads and then writes the word
// of each cell of the clipped rectangle in turn, as the memory has a single read port.
// After reset, and for each clear-all item, a clearing pass writes one word per cycle
// over all ceil(MAX_COLUMNS * MAX_ROWS / 32) words (2048 with the defaults); no item
// is taken during the pass, configuration writes are. Every item returns the state of
// the cell at its position after the operation and the count.
// Issue clear-all after changing the map size.
module occupancy_grid_store #(
    parameter int unsigned MAX_COLUMNS = ogs_pkg::DEF_MAX_COLUMNS,
    parameter int unsigned MAX_ROWS    = ogs_pkg::DEF_MAX_ROWS
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [ogs_pkg::KIND_W-1:0]         kind,
    input  logic signed [ogs_pkg::POS_W-1:0]   pos_x,
    input  logic signed [ogs_pkg::POS_W-1:0]   pos_y,
    input  logic [ogs_pkg::DIM_W-1:0]          rect_w,
    input  logic [ogs_pkg::DIM_W-1:0]          rect_h,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               cell_obstacle,
    output logic                               cell_in_bounds,
    output logic                               cell_free,
    output logic [ogs_pkg::TALLY_W-1:0]        obstacle_total,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ogs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ogs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import ogs_pkg::*;

    localparam int unsigned CELLS   = MAX_COLUMNS * MAX_ROWS;
    localparam int unsigned WORDS   = (CELLS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned ADDR_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned IDX_W   = ADDR_W + BIT_SEL_W;
    localparam int unsigned PROD_W  = 2 * DIM_W;
    localparam int unsigned SUM_W   = PROD_W + 1;
    localparam int unsigned CRD_W   = POS_W + 2;
    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORDS - 1);

    state_t state_reg, state_next;

    logic [DIM_W-1:0]     map_width_reg;
    logic [DIM_W-1:0]     map_height_reg;
    logic [DIM_W-1:0]     eff_w;
    logic [DIM_W-1:0]     eff_h;

    logic [ADDR_W-1:0]    clr_cnt_reg;
    logic                 clr_item_reg;
    logic [TALLY_W-1:0]   tally_reg;
    logic                 out_valid_reg;

    logic signed [POS_W-1:0] px_reg;
    logic signed [POS_W-1:0] py_reg;
    logic                 wr_val_reg;
    logic [DIM_W-1:0]     x_cur_reg;
    logic [DIM_W-1:0]     y_cur_reg;
    logic [DIM_W-1:0]     xs_reg;
    logic [DIM_W-1:0]     xe_reg;
    logic [DIM_W-1:0]     ye_reg;
    logic [ADDR_W-1:0]    wr_addr_reg;
    logic [BIT_SEL_W-1:0] bit_sel_reg;
    logic                 obst_reg;
    logic                 inb_reg;
    logic                 free_reg;
    logic [TALLY_W-1:0]   total_reg;

    logic                 in_acc;
    kind_t                kind_in;
    logic                 is_write;
    logic [DIM_W-1:0]     span_w;
    logic [DIM_W-1:0]     span_h;
    logic signed [CRD_W-1:0] px_in;
    logic signed [CRD_W-1:0] py_in;
    logic signed [CRD_W-1:0] effw_s;
    logic signed [CRD_W-1:0] effh_s;
    logic signed [CRD_W-1:0] x_end;
    logic signed [CRD_W-1:0] y_end;
    logic signed [CRD_W-1:0] xs_c;
    logic signed [CRD_W-1:0] ys_c;
    logic signed [CRD_W-1:0] xe_c;
    logic signed [CRD_W-1:0] ye_c;
    logic                 span_ok;

    logic signed [CRD_W-1:0] px_q;
    logic signed [CRD_W-1:0] py_q;
    logic                 inb;

    logic [DIM_W-1:0]     mul_x;
    logic [DIM_W-1:0]     mul_y;
    logic [PROD_W-1:0]    prod;
    logic [SUM_W-1:0]     idx_wide;
    logic [IDX_W-1:0]     idx;

    logic [DIM_W:0]       x_inc;
    logic [DIM_W:0]       y_inc;
    logic                 row_end;
    logic                 last_cell;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [WORD_BITS-1:0] rd_word;
    logic [WORD_BITS-1:0] mod_word;
    logic                 old_bit;
    logic                 load_out;

    ogs_mem #(
        .DEPTH  (WORDS),
        .ADDR_W (ADDR_W),
        .DATA_W (WORD_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (idx[IDX_W-1:BIT_SEL_W]),
        .rdata (rd_word)
    );

    assign eff_w = eff_dim(map_width_reg, MAX_COLUMNS);
    assign eff_h = eff_dim(map_height_reg, MAX_ROWS);

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Set and clear are one-cell rectangles; the clip handles the bounds check.
    assign kind_in  = kind_t'(kind);
    assign is_write = (kind_in == KIND_SET) || (kind_in == KIND_CLEAR)
                      || (kind_in == KIND_FILL);
    assign span_w   = (kind_in != KIND_FILL) ? DIM_W'(1)
                    : ((rect_w == '0) ? DIM_W'(1) : rect_w);
    assign span_h   = (kind_in != KIND_FILL) ? DIM_W'(1)
                    : ((rect_h == '0) ? DIM_W'(1) : rect_h);

    assign px_in  = CRD_W'(pos_x);
    assign py_in  = CRD_W'(pos_y);
    assign effw_s = signed'({{(CRD_W-DIM_W){1'b0}}, eff_w});
    assign effh_s = signed'({{(CRD_W-DIM_W){1'b0}}, eff_h});
    assign x_end  = px_in + signed'({{(CRD_W-DIM_W){1'b0}}, span_w});
    assign y_end  = py_in + signed'({{(CRD_W-DIM_W){1'b0}}, span_h});
    assign xs_c   = (px_in < 0) ? '0 : px_in;
    assign ys_c   = (py_in < 0) ? '0 : py_in;
    assign xe_c   = (x_end > effw_s) ? effw_s : x_end;
    assign ye_c   = (y_end > effh_s) ? effh_s : y_end;
    assign span_ok = (xs_c < xe_c) && (ys_c < ye_c);

    assign px_q = CRD_W'(px_reg);
    assign py_q = CRD_W'(py_reg);
    assign inb  = (px_q >= 0) && (py_q >= 0) && (px_q < effw_s) && (py_q < effh_s);

    assign mul_x    = (state_reg == ST_QUERY_RD) ? (inb ? px_reg[DIM_W-1:0] : '0) : x_cur_reg;
    assign mul_y    = (state_reg == ST_QUERY_RD) ? (inb ? py_reg[DIM_W-1:0] : '0) : y_cur_reg;
    assign prod     = PROD_W'(mul_y) * PROD_W'(eff_w);
    assign idx_wide = SUM_W'(prod) + SUM_W'(mul_x);
    assign idx      = IDX_W'(idx_wide);

    assign x_inc     = {1'b0, x_cur_reg} + (DIM_W+1)'(1);
    assign y_inc     = {1'b0, y_cur_reg} + (DIM_W+1)'(1);
    assign row_end   = (x_inc == {1'b0, xe_reg});
    assign last_cell = row_end && (y_inc == {1'b0, ye_reg});

    always_comb
    begin
        mod_word = rd_word;
        mod_word[bit_sel_reg] = wr_val_reg;
    end

    assign old_bit = rd_word[bit_sel_reg];

    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = wr_addr_reg;
        mem_wdata  = mod_word;
        mem_re     = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == LAST_WORD)
                begin
                    state_next = clr_item_reg ? ST_QUERY_RD : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (kind_in == KIND_CLEAR_ALL)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (is_write && span_ok)
                    begin
                        state_next = ST_CELL_RD;
                    end
                    else
                    begin
                        state_next = ST_QUERY_RD;
                    end
                end
            end
            ST_CELL_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_CELL_WR;
            end
            ST_CELL_WR:
            begin
                mem_we     = 1'b1;
                state_next = last_cell ? ST_QUERY_RD : ST_CELL_RD;
            end
            ST_QUERY_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= DIM_W'(256);
            map_height_reg <= DIM_W'(256);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                CFG_MAP_HEIGHT: map_height_reg <= cfg_data;
                default:        map_width_reg  <= map_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            clr_item_reg  <= 1'b0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_CLEAR)
            begin
                tally_reg <= '0;
                if (clr_cnt_reg == LAST_WORD)
                begin
                    clr_cnt_reg  <= '0;
                    clr_item_reg <= 1'b0;
                end
                else
                begin
                    clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                end
            end
            if (in_acc && (kind_in == KIND_CLEAR_ALL))
            begin
                clr_item_reg <= 1'b1;
            end
            if (state_reg == ST_CELL_WR)
            begin
                if (wr_val_reg && !old_bit)
                begin
                    tally_reg <= tally_reg + TALLY_W'(1);
                end
                else if (!wr_val_reg && old_bit)
                begin
                    tally_reg <= tally_reg - TALLY_W'(1);
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            px_reg     <= pos_x;
            py_reg     <= pos_y;
            wr_val_reg <= (kind_in != KIND_CLEAR);
            xs_reg     <= xs_c[DIM_W-1:0];
            xe_reg     <= xe_c[DIM_W-1:0];
            ye_reg     <= ye_c[DIM_W-1:0];
            x_cur_reg  <= xs_c[DIM_W-1:0];
            y_cur_reg  <= ys_c[DIM_W-1:0];
        end
        if (mem_re)
        begin
            wr_addr_reg <= idx[IDX_W-1:BIT_SEL_W];
            bit_sel_reg <= idx[BIT_SEL_W-1:0];
        end
        if (state_reg == ST_CELL_WR)
        begin
            if (row_end)
            begin
                x_cur_reg <= xs_reg;
                y_cur_reg <= y_inc[DIM_W-1:0];
            end
            else
            begin
                x_cur_reg <= x_inc[DIM_W-1:0];
            end
        end
        if (load_out)
        begin
            obst_reg  <= inb ? old_bit : 1'b1;
            inb_reg   <= inb;
            free_reg  <= inb && !old_bit;
            total_reg <= tally_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cell_obstacle  = obst_reg;
    assign cell_in_bounds = inb_reg;
    assign cell_free      = free_reg;
    assign obstacle_total = total_reg;

endmodule
